// ===== hw/rtl/hci_command_exchange_assert.svh =====
// ----------------------------------------------------------------------------
// hci command exchange assertion macros
// concurrent checks on clk, switched off as a set by NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef HCI_COMMAND_EXCHANGE_ASSERT_SVH
`define HCI_COMMAND_EXCHANGE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define HCX_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("hci command exchange assertion failed");

// condition must never be seen at a clock edge out of reset
`define HCX_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("hci command exchange forbidden condition seen");

`else

`define HCX_ASSERT(lbl, prop)
`define HCX_NEVER(lbl, cond)

`endif

`endif

// ===== hw/rtl/hci_cx_pkg.sv =====
// ----------------------------------------------------------------------------
// hci command exchange package
// shared types and constants of the h4 command engine
// ----------------------------------------------------------------------------
package hci_cx_pkg;

	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned MAX_RES    = 4;
	localparam int unsigned CNT_W      = $clog2(MAX_RES + 1);
	localparam int unsigned POS_W      = $clog2(MAX_RES);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CMD_IND  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EVT_IND  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ST_CODE  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CC_CODE  = 8'd3;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_PAYLOAD = 2'd1,
		CMD_RX      = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [5:0]  group;
		logic [9:0]  command_code;
		logic [7:0]  payload_length;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] cmd_ind;
		logic [7:0] evt_ind;
		logic [7:0] st_code;
		logic [7:0] cc_code;
	} cfg_t;

	// results caused by one item, bytes[0] goes out first
	typedef struct packed {
		logic [CNT_W-1:0]        count;
		logic                    kind;
		logic [3:0]              completion;
		logic [MAX_RES-1:0][7:0] bytes;
	} res_grp_t;

endpackage

// ===== hw/rtl/hci_cx_in_reg.sv =====
// ----------------------------------------------------------------------------
// hci command exchange input register
// holds one accepted request until the engine takes it
// ----------------------------------------------------------------------------
module hci_cx_in_reg
	import hci_cx_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_valid,
	output logic                 s_ready,
	input  logic [IN_DATA_W-1:0] s_data,
	input  logic [IN_USER_W-1:0] s_user,
	input  logic                 consume,
	output logic                 valid_s1,
	output item_t                item_s1
);

	logic  take;
	item_t item_d;

	assign s_ready = !valid_s1 || consume;
	assign take    = s_valid && s_ready;

	// unpack the stream word
	always_comb begin
		item_d.command        = cmd_t'(s_user);
		item_d.group          = s_data[5:0];
		item_d.command_code   = s_data[15:6];
		item_d.payload_length = s_data[23:16];
		item_d.data_byte      = s_data[31:24];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ===== hw/rtl/hci_cx_engine.sv =====
// ----------------------------------------------------------------------------
// hci command exchange engine
// command state and response checks, one request per cycle while the emitter can take its results
// ----------------------------------------------------------------------------
`include "hci_command_exchange_assert.svh"

module hci_cx_engine
	import hci_cx_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  item_t    item_s1,
	input  logic     fire,
	output res_grp_t grp
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_PAYLOAD, PH_IND, PH_CODE, PH_LEN, PH_B1, PH_B2, PH_B3, PH_B4
	} phase_t;

	localparam logic [7:0] EVT_LEN = 8'd4;

	localparam logic [3:0] COMP_OK      = 4'd0;
	localparam logic [3:0] COMP_IND     = 4'd1;
	localparam logic [3:0] COMP_ST_LEN  = 4'd2;
	localparam logic [3:0] COMP_ST_CRED = 4'd3;
	localparam logic [3:0] COMP_ST_OPLO = 4'd4;
	localparam logic [3:0] COMP_ST_OPHI = 4'd5;
	localparam logic [3:0] COMP_CC_LEN  = 4'd6;
	localparam logic [3:0] COMP_CC_CRED = 4'd7;
	localparam logic [3:0] COMP_CC_OPLO = 4'd8;
	localparam logic [3:0] COMP_CC_OPHI = 4'd9;
	localparam logic [3:0] COMP_CC_RET  = 4'd10;
	localparam logic [3:0] COMP_CODE    = 4'd11;
	localparam logic [3:0] COMP_ST_STAT = 4'd12;

	phase_t      phase_q, phase_d;
	logic [15:0] opcode_q, opcode_d;
	logic [7:0]  left_q, left_d;
	logic        stat_q, stat_d;
	logic        done;
	logic [3:0]  comp;
	logic [15:0] new_op;
	logic [7:0]  b;

	assign b      = item_s1.data_byte;
	assign new_op = {item_s1.group, item_s1.command_code};

	always_comb begin
		phase_d  = phase_q;
		opcode_d = opcode_q;
		left_d   = left_q;
		stat_d   = stat_q;
		done     = 1'b0;
		comp     = COMP_OK;
		grp      = '0;
		case (item_s1.command)
			CMD_START: begin
				opcode_d   = new_op;
				left_d     = item_s1.payload_length;
				stat_d     = 1'b0;
				phase_d    = (item_s1.payload_length != 8'd0) ? PH_PAYLOAD : PH_IND;
				grp.count  = CNT_W'(MAX_RES);
				grp.bytes[0] = cfg.cmd_ind;
				grp.bytes[1] = new_op[7:0];
				grp.bytes[2] = new_op[15:8];
				grp.bytes[3] = item_s1.payload_length;
			end
			CMD_PAYLOAD: begin
				if (phase_q == PH_PAYLOAD) begin
					grp.count    = CNT_W'(1);
					grp.bytes[0] = b;
					left_d       = left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_d = PH_IND;
					end
				end
			end
			CMD_RX: begin
				case (phase_q)
					PH_IND: begin
						if (b != cfg.evt_ind) begin
							done = 1'b1;
							comp = COMP_IND;
						end else begin
							phase_d = PH_CODE;
						end
					end
					PH_CODE: begin
						// status path wins when both codes match
						if (b == cfg.st_code) begin
							stat_d  = 1'b1;
							phase_d = PH_LEN;
						end else if (b == cfg.cc_code) begin
							stat_d  = 1'b0;
							phase_d = PH_LEN;
						end else begin
							done = 1'b1;
							comp = COMP_CODE;
						end
					end
					PH_LEN: begin
						if (b != EVT_LEN) begin
							done = 1'b1;
							comp = stat_q ? COMP_ST_LEN : COMP_CC_LEN;
						end else begin
							phase_d = PH_B1;
						end
					end
					PH_B1: begin
						if (stat_q ? (b != 8'd0) : (b == 8'd0)) begin
							done = 1'b1;
							comp = stat_q ? COMP_ST_STAT : COMP_CC_CRED;
						end else begin
							phase_d = PH_B2;
						end
					end
					PH_B2: begin
						if (stat_q ? (b == 8'd0) : (b != opcode_q[7:0])) begin
							done = 1'b1;
							comp = stat_q ? COMP_ST_CRED : COMP_CC_OPLO;
						end else begin
							phase_d = PH_B3;
						end
					end
					PH_B3: begin
						if (stat_q ? (b != opcode_q[7:0]) : (b != opcode_q[15:8])) begin
							done = 1'b1;
							comp = stat_q ? COMP_ST_OPLO : COMP_CC_OPHI;
						end else begin
							phase_d = PH_B4;
						end
					end
					PH_B4: begin
						done = 1'b1;
						if (stat_q ? (b != opcode_q[15:8]) : (b != 8'd0)) begin
							comp = stat_q ? COMP_ST_OPHI : COMP_CC_RET;
						end else begin
							comp = COMP_OK;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
		if (done) begin
			phase_d        = PH_IDLE;
			grp.count      = CNT_W'(1);
			grp.kind       = 1'b1;
			grp.completion = comp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			opcode_q <= '0;
			left_q   <= '0;
			stat_q   <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			left_q   <= left_d;
			stat_q   <= stat_d;
		end
	end

	`HCX_NEVER(a_payload_left, (phase_q == PH_PAYLOAD) && (left_q == 8'd0))
	`HCX_ASSERT(a_finish_idle, (fire && grp.kind) |=> (phase_q == PH_IDLE))
	`HCX_ASSERT(a_start_phase,
		(fire && (item_s1.command == CMD_START)) |=>
		((phase_q == PH_PAYLOAD) || (phase_q == PH_IND)))

endmodule

// ===== hw/rtl/hci_cx_emit.sv =====
// ----------------------------------------------------------------------------
// hci command exchange result emitter
// holds one request's results and sends them one per cycle while the receiver is ready
// ----------------------------------------------------------------------------
`include "hci_command_exchange_assert.svh"

module hci_cx_emit
	import hci_cx_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  res_grp_t              grp,
	output logic                  can_load,
	output logic                  m_valid,
	input  logic                  m_ready,
	output logic [OUT_DATA_W-1:0] m_data,
	output logic                  m_user,
	output logic                  m_last
);

	res_grp_t         grp_q;
	logic [CNT_W-1:0] left_q;
	logic [POS_W-1:0] pos_q;
	logic             hs;
	logic             take;

	assign m_valid  = (left_q != '0);
	assign hs       = m_valid && m_ready;
	assign can_load = (left_q == '0) || ((left_q == CNT_W'(1)) && m_ready);
	assign take     = load && (grp.count != '0);

	assign m_user = grp_q.kind;
	assign m_last = (left_q == CNT_W'(1));
	assign m_data = {{(OUT_DATA_W - 12){1'b0}}, grp_q.completion, grp_q.bytes[pos_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			pos_q  <= '0;
		end else if (take) begin
			left_q <= grp.count;
			pos_q  <= '0;
		end else if (hs) begin
			left_q <= left_q - CNT_W'(1);
			pos_q  <= pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			grp_q <= grp;
		end
	end

	`HCX_ASSERT(a_load_free, take |-> ((left_q == '0) || (hs && (left_q == CNT_W'(1)))))
	`HCX_NEVER(a_pos_range, ({1'b0, pos_q} + left_q) > CNT_W'(MAX_RES))
	`HCX_ASSERT(a_finish_single, (take && grp.kind) |=> (left_q == CNT_W'(1)))

endmodule

// ===== hw/rtl/hci_command_exchange.sv =====
// ----------------------------------------------------------------------------
// hci command exchange
// h4 host-side hci command engine: sends the command header and payload,
// then checks the command status or command complete event
// ----------------------------------------------------------------------------
//
//  channel   | dir | tdata / data                             | tuser / other
//  ----------+-----+------------------------------------------+-------------------
//  s_axis    | in  | group, command_code, payload_length, byte| command
//  m_axis    | out | tx_byte, completion                      | kind, tlast = last
//  cfg       | in  | cfg_data: register value                 | cfg_index
//
//  a request waits in the input register, is handled in one pass and its
//  results go to the output register, so one request a cycle is taken while
//  the output is free; a start request gives four bytes and holds the output
//  until all are taken; payload bytes and finishing response bytes give one
//  result, other bytes none; the input register is freed when the output can
//  take the request's results, also in the cycle the last held result is taken
//  reset clears the state, the output and the registers to their defaults;
//  no clearing pass
//
// ----------------------------------------------------------------------------
module hci_command_exchange
	import hci_cx_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// request stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // group, command_code, payload_length, data_byte
	input  logic [IN_USER_W-1:0]  s_axis_tuser,  // command
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // tx_byte, completion, zero fill
	output logic                  m_axis_tuser,  // kind
	output logic                  m_axis_tlast,  // last result of the request
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]            cfg_data
);

	cfg_t     cfg_q;
	item_t    item_s1;
	logic     valid_s1;
	logic     can_load;
	logic     fire;
	res_grp_t grp;

	// register writes always land at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cmd_ind <= 8'd1;
			cfg_q.evt_ind <= 8'd4;
			cfg_q.st_code <= 8'd15;
			cfg_q.cc_code <= 8'd14;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CMD_IND: cfg_q.cmd_ind <= cfg_data;
				REG_EVT_IND: cfg_q.evt_ind <= cfg_data;
				REG_ST_CODE: cfg_q.st_code <= cfg_data;
				REG_CC_CODE: cfg_q.cc_code <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// request handled when the output can hold all its results
	assign fire = valid_s1 && can_load;

	hci_cx_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_axis_tvalid),
		.s_ready  (s_axis_tready),
		.s_data   (s_axis_tdata),
		.s_user   (s_axis_tuser),
		.consume  (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	hci_cx_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item_s1 (item_s1),
		.fire    (fire),
		.grp     (grp)
	);

	hci_cx_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire),
		.grp      (grp),
		.can_load (can_load),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.m_data   (m_axis_tdata),
		.m_user   (m_axis_tuser),
		.m_last   (m_axis_tlast)
	);

endmodule

// ===== sim/hci_command_exchange_test.sv =====
// ----------------------------------------------------------------------------
// hci command exchange testbench
// drives start, payload and received-byte requests into the h4 command engine,
// predicts every transmitted byte and completion in a scoreboard and compares
// the result stream field by field, over several register settings and with
// random idling on the request side and random stalls on the result side
// ----------------------------------------------------------------------------
module hci_command_exchange_test
	import hci_cx_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// run length and drain allowance
	localparam int unsigned CYCLE_LIMIT     = 500000;
	localparam int unsigned DRAIN_CYCLES    = 10;
	localparam int          ITEMS_PER_PHASE = 95;

	// unused command value, the block must ignore it
	localparam logic [1:0] CMD_RESERVED = 2'd3;

	// fixed parts of a well-formed response event
	localparam logic [7:0] EVT_PARAM_LEN = 8'd4;
	localparam logic [7:0] STATUS_OK     = 8'd0;

	localparam cfg_t RESET_SETTINGS = '{cmd_ind: 8'd1, evt_ind: 8'd4,
		st_code: 8'd15, cc_code: 8'd14};

	typedef enum logic [3:0] {
		EX_IDLE,
		EX_PAYLOAD,
		EX_INDICATOR,
		EX_EVENT_CODE,
		EX_LENGTH,
		EX_PARAM1,
		EX_PARAM2,
		EX_PARAM3,
		EX_PARAM4
	} exchange_stage_t;

	typedef enum logic [3:0] {
		COMP_SUCCESS      = 4'd0,
		COMP_BAD_IND      = 4'd1,
		COMP_ST_LENGTH    = 4'd2,
		COMP_ST_CREDITS   = 4'd3,
		COMP_ST_OPCODE_LO = 4'd4,
		COMP_ST_OPCODE_HI = 4'd5,
		COMP_CC_LENGTH    = 4'd6,
		COMP_CC_CREDITS   = 4'd7,
		COMP_CC_OPCODE_LO = 4'd8,
		COMP_CC_OPCODE_HI = 4'd9,
		COMP_CC_RETURN    = 4'd10,
		COMP_BAD_EVENT    = 4'd11,
		COMP_ST_STATUS    = 4'd12
	} completion_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] tx_byte;
		logic [3:0] completion;
		logic       last;
	} output_result_t;

	// seven bytes of a response event, index 0 received first
	typedef logic [6:0][7:0] event_bytes_t;

	// scoreboard: own copy of the engine state and registers
	class exchange_scoreboard;
		cfg_t             regs = RESET_SETTINGS;
		exchange_stage_t  stage = EX_IDLE;
		logic [15:0]      opcode = '0;
		logic [7:0]       payload_left = '0;
		bit               status_path = 1'b0;
		output_result_t   awaited_outputs[$];
		int               mismatches = 0;

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
			case (idx)
				REG_CMD_IND: regs.cmd_ind = value;
				REG_EVT_IND: regs.evt_ind = value;
				REG_ST_CODE: regs.st_code = value;
				REG_CC_CODE: regs.cc_code = value;
				default: ;
			endcase
		endfunction

		function void push_tx(logic [7:0] value, logic last);
			awaited_outputs.push_back('{kind: 1'b0, tx_byte: value,
				completion: COMP_SUCCESS, last: last});
		endfunction

		function void finish(completion_t code);
			stage = EX_IDLE;
			awaited_outputs.push_back('{kind: 1'b1, tx_byte: 8'd0,
				completion: code, last: 1'b1});
		endfunction

		function void receive_byte(logic [7:0] b);
			case (stage)
				EX_INDICATOR:
					if (b != regs.evt_ind) finish(COMP_BAD_IND);
					else stage = EX_EVENT_CODE;
				EX_EVENT_CODE:
					if (b == regs.st_code) begin
						status_path = 1'b1;
						stage = EX_LENGTH;
					end else if (b == regs.cc_code) begin
						status_path = 1'b0;
						stage = EX_LENGTH;
					end else begin
						finish(COMP_BAD_EVENT);
					end
				EX_LENGTH:
					if (b != EVT_PARAM_LEN)
						finish(status_path ? COMP_ST_LENGTH : COMP_CC_LENGTH);
					else stage = EX_PARAM1;
				EX_PARAM1:
					if (status_path ? (b != STATUS_OK) : (b == 8'd0))
						finish(status_path ? COMP_ST_STATUS : COMP_CC_CREDITS);
					else stage = EX_PARAM2;
				EX_PARAM2:
					if (status_path ? (b == 8'd0) : (b != opcode[7:0]))
						finish(status_path ? COMP_ST_CREDITS : COMP_CC_OPCODE_LO);
					else stage = EX_PARAM3;
				EX_PARAM3:
					if (status_path ? (b != opcode[7:0]) : (b != opcode[15:8]))
						finish(status_path ? COMP_ST_OPCODE_LO : COMP_CC_OPCODE_HI);
					else stage = EX_PARAM4;
				EX_PARAM4:
					if (status_path ? (b != opcode[15:8]) : (b != STATUS_OK))
						finish(status_path ? COMP_ST_OPCODE_HI : COMP_CC_RETURN);
					else finish(COMP_SUCCESS);
				default: ;
			endcase
		endfunction

		function void note_request(item_t req);
			case (req.command)
				CMD_START: begin
					opcode = {req.group, req.command_code};
					payload_left = req.payload_length;
					status_path = 1'b0;
					stage = (req.payload_length != 8'd0) ? EX_PAYLOAD : EX_INDICATOR;
					push_tx(regs.cmd_ind, 1'b0);
					push_tx(opcode[7:0], 1'b0);
					push_tx(opcode[15:8], 1'b0);
					push_tx(req.payload_length, 1'b1);
				end
				CMD_PAYLOAD:
					if (stage == EX_PAYLOAD) begin
						push_tx(req.data_byte, 1'b1);
						payload_left = payload_left - 8'd1;
						if (payload_left == 8'd0) stage = EX_INDICATOR;
					end
				CMD_RX: receive_byte(req.data_byte);
				default: ;
			endcase
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned seen);
			if (want != seen) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, field, want, seen);
				mismatches++;
			end
		endfunction

		function void check_result(output_result_t got);
			output_result_t want;
			if (awaited_outputs.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d byte %0d comp %0d",
					$time, got.kind, got.tx_byte, got.completion);
				mismatches++;
				return;
			end
			want = awaited_outputs.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("tx_byte", want.tx_byte, got.tx_byte);
			compare_field("completion", want.completion, got.completion);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // group, command_code, payload_length, data_byte
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // command
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // tx_byte, completion, zero fill
	logic                  m_axis_tuser;        // kind
	logic                  m_axis_tlast;        // last result of the request
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [7:0]            cfg_data = '0;

	// idling percentages of the current phase
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	int          items_sent = 0;
	int unsigned cycle_count = 0;

	exchange_scoreboard sb;

	hci_command_exchange DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 20 ns clock period
	always #10 clk = ~clk;

	// result side stalls, decided afresh at every falling edge
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached", $time);
			$display("Mismatches found");
			$finish;
		end
	end

	// observe all three channels at the rising edge; results are checked first
	// so that a result is never matched against a request taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(output_result_t'{m_axis_tuser, m_axis_tdata[7:0],
					m_axis_tdata[11:8], m_axis_tlast});
			if (s_axis_tvalid && s_axis_tready)
				sb.note_request({s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[15:6],
					s_axis_tdata[23:16], s_axis_tdata[31:24]});
			if (cfg_valid && cfg_ready)
				sb.set_register(cfg_index, cfg_data);
		end
	end

	// one request, entered at a falling edge and left at the falling edge after
	// it was taken; tvalid stays high for a back-to-back request
	task automatic send_request(input logic [1:0] cmd, input logic [5:0] grp,
		input logic [9:0] code, input logic [7:0] plen, input logic [7:0] b,
		input bit counted);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {b, plen, code, grp};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		if (counted) items_sent++;
	endtask

	task automatic drive_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic write_settings(input cfg_t settings);
		drive_register(REG_CMD_IND, settings.cmd_ind);
		drive_register(REG_EVT_IND, settings.evt_ind);
		drive_register(REG_ST_CODE, settings.st_code);
		drive_register(REG_CC_CODE, settings.cc_code);
		cfg_valid <= 1'b0;
	endtask

	// wait for every predicted result, then let trailing ignored requests settle
	task automatic wait_for_drain();
		while (sb.awaited_outputs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// well-formed command status or command complete event for an opcode
	function automatic event_bytes_t build_event(bit on_status, logic [15:0] op,
		logic [7:0] credits);
		event_bytes_t ev;
		ev[0] = sb.regs.evt_ind;
		ev[2] = EVT_PARAM_LEN;
		if (on_status) begin
			ev[1] = sb.regs.st_code;
			ev[3] = STATUS_OK;
			ev[4] = credits;
			ev[5] = op[7:0];
			ev[6] = op[15:8];
		end else begin
			ev[1] = sb.regs.cc_code;
			ev[3] = credits;
			ev[4] = op[7:0];
			ev[5] = op[15:8];
			ev[6] = STATUS_OK;
		end
		return ev;
	endfunction

	task automatic send_event(input event_bytes_t ev);
		for (int i = 0; i < 7; i++)
			send_request(CMD_RX, 6'($urandom), 10'($urandom), 8'($urandom), ev[i], 1'b1);
	endtask

	// one exchange with random content: optional noise, a start request, the
	// payload and a response that may be corrupted in one byte or cut short
	task automatic run_exchange();
		logic [5:0]   grp;
		logic [9:0]   code;
		logic [7:0]   plen;
		event_bytes_t ev;
		int           pick;
		int           total;
		int           cut;
		if ($urandom_range(99) < 10) begin
			repeat ($urandom_range(1, 3))
				send_request(2'($urandom_range(1, 3)), 6'($urandom), 10'($urandom),
					8'($urandom), 8'($urandom), 1'b0);
		end
		grp  = 6'($urandom);
		code = 10'($urandom);
		pick = $urandom_range(99);
		// mostly short payloads, now and then a long one
		if (pick < 3) plen = 8'($urandom);
		else if (pick < 25) plen = 8'd0;
		else plen = 8'($urandom_range(1, 6));
		ev = build_event(1'($urandom), {grp, code}, 8'($urandom_range(1, 255)));
		if ($urandom_range(99) < 35)
			ev[$urandom_range(6)] = $urandom_range(1) ? 8'($urandom) : 8'd0;
		total = plen + 7;
		// a cut exchange is abandoned by the next start request
		cut = ($urandom_range(99) < 12) ? $urandom_range(total - 1) : total;
		send_request(CMD_START, grp, code, plen, 8'($urandom), 1'b1);
		for (int i = 0; i < cut; i++) begin
			if (i < plen) begin
				// received byte while payload is still due, ignored
				if ($urandom_range(99) < 4)
					send_request(CMD_RX, 6'($urandom), 10'($urandom), 8'($urandom),
						8'($urandom), 1'b0);
				send_request(CMD_PAYLOAD, 6'($urandom), 10'($urandom), 8'($urandom),
					8'($urandom), 1'b1);
			end else begin
				send_request(CMD_RX, 6'($urandom), 10'($urandom), 8'($urandom),
					ev[i - plen], 1'b1);
			end
		end
	endtask

	task automatic run_phase(input cfg_t settings, input int unsigned sender_pct,
		input int unsigned receiver_pct);
		int goal;
		s_axis_tvalid <= 1'b0;
		wait_for_drain();
		write_settings(settings);
		sender_idle_pct    = sender_pct;
		receiver_stall_pct = receiver_pct;
		goal = items_sent + ITEMS_PER_PHASE;
		while (items_sent < goal) run_exchange();
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, reset settings, no idling
		// stray requests while idle: received byte, payload byte, unused command
		send_request(CMD_RX, 6'd0, 10'd0, 8'd0, 8'hFF, 1'b1);
		send_request(CMD_PAYLOAD, 6'd0, 10'd0, 8'd0, 8'hFF, 1'b1);
		send_request(CMD_RESERVED, 6'h3F, 10'h3FF, 8'hFF, 8'hFF, 1'b1);
		// largest opcode, no payload, response straight after the header
		send_request(CMD_START, 6'h3F, 10'h3FF, 8'd0, 8'hFF, 1'b1);
		send_event(build_event(1'b0, 16'hFFFF, 8'hFF));
		// longest payload, abandoned by a start while busy
		send_request(CMD_START, 6'd0, 10'd0, 8'hFF, 8'h00, 1'b1);
		send_request(CMD_PAYLOAD, 6'h3F, 10'h3FF, 8'hFF, 8'hFF, 1'b1);
		send_request(CMD_RX, 6'h3F, 10'h3FF, 8'hFF, 8'h00, 1'b1);
		send_request(CMD_PAYLOAD, 6'd0, 10'd0, 8'd0, 8'h00, 1'b1);
		send_request(CMD_START, 6'h2A, 10'h155, 8'd1, 8'h00, 1'b1);
		send_request(CMD_PAYLOAD, 6'd0, 10'd0, 8'd0, 8'hA5, 1'b1);
		send_event(build_event(1'b1, {6'h2A, 10'h155}, 8'h01));

		// random phases with different settings and idling
		run_phase('{cmd_ind: 8'hFF, evt_ind: 8'h00, st_code: 8'hFF, cc_code: 8'h00},
			0, 0);
		// equal event codes, the status path must win
		run_phase('{cmd_ind: 8'h00, evt_ind: 8'hFF, st_code: 8'h3C, cc_code: 8'h3C},
			82, 0);
		run_phase('{cmd_ind: 8'($urandom), evt_ind: 8'($urandom),
			st_code: 8'($urandom), cc_code: 8'($urandom)}, 0, 82);
		run_phase(RESET_SETTINGS, 31, 31);

		s_axis_tvalid <= 1'b0;
		wait_for_drain();
		if (sb.awaited_outputs.size() != 0)
			$display("%0t: results outstanding, expected 0, actual %0d",
				$time, sb.awaited_outputs.size());
		if (sb.mismatches == 0 && sb.awaited_outputs.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
